>>> rtl/iort_pkg.sv
// ----------------------------------------------------------------------------
// iort_pkg
// Shared types and constants of the interval offset remap table: command and
// status codes, payload widths and the controller to datapath bundles.
// ----------------------------------------------------------------------------
`default_nettype none

package iort_pkg;

	// payload widths of the channels
	localparam int FIELD_BITS  = 40;
	localparam int OFFSET_BITS = 41;
	localparam int CMD_BITS    = 2;
	localparam int STATUS_BITS = 2;

	// defaults of the top level parameters
	localparam int DEF_TABLE_ENTRIES = 16;
	localparam int DEF_VALUE_BITS    = 40;

	// command codes
	localparam logic [CMD_BITS-1:0] CMD_INSERT  = 2'd0;
	localparam logic [CMD_BITS-1:0] CMD_CONVERT = 2'd1;
	localparam logic [CMD_BITS-1:0] CMD_LOOKUP  = 2'd2;
	localparam logic [CMD_BITS-1:0] CMD_CLEAR   = 2'd3;

	// result status codes
	localparam logic [STATUS_BITS-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_BITS-1:0] ST_FULL  = 2'd1;
	localparam logic [STATUS_BITS-1:0] ST_ORDER = 2'd2;
	localparam logic [STATUS_BITS-1:0] ST_RANGE = 2'd3;

	// commands from the controller to the datapath
	typedef struct packed {
		logic                   accept;      // latch the request fields
		logic                   clear_tab;   // drop all entries
		logic                   set_simple;  // load a result with zero values
		logic [STATUS_BITS-1:0] code;        // status of that result
		logic                   shift_step;  // move one entry up by one slot
		logic                   ins_write;   // write the new entry, load ok result
		logic                   scan_init;   // restart the entry walk
		logic                   scan_step;   // examine one entry
		logic                   load_piece;  // build the mapped piece result
		logic                   next_piece;  // step past the delivered piece
	} ctl_t;

	// status from the datapath to the controller
	typedef struct packed {
		logic [CMD_BITS-1:0] cmd;
		logic                lo_gt_hi;
		logic                full;
		logic                shift_more;
		logic                scan_done;
		logic                last_q;
	} sts_t;

endpackage

`default_nettype wire

>>> rtl/iort_in_if.sv
// ----------------------------------------------------------------------------
// iort_in_if
// Request channel: valid/ready handshake with command and range fields.
// ----------------------------------------------------------------------------
`default_nettype none

interface iort_in_if;
	logic                                 valid;
	logic                                 ready;
	logic [iort_pkg::CMD_BITS-1:0]        command;
	logic [iort_pkg::FIELD_BITS-1:0]      low_value;
	logic [iort_pkg::FIELD_BITS-1:0]      high_value;
	logic signed [iort_pkg::OFFSET_BITS-1:0] offset;

	modport source (output valid, command, low_value, high_value, offset, input ready);
	modport sink (input valid, command, low_value, high_value, offset, output ready);
endinterface

`default_nettype wire

>>> rtl/iort_out_if.sv
// ----------------------------------------------------------------------------
// iort_out_if
// Response channel: valid/ready handshake with one mapped piece per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface iort_out_if;
	logic                               valid;
	logic                               ready;
	logic [iort_pkg::FIELD_BITS-1:0]    out_low;
	logic [iort_pkg::FIELD_BITS-1:0]    out_high;
	logic                               last_piece;
	logic [iort_pkg::STATUS_BITS-1:0]   status;

	modport source (output valid, out_low, out_high, last_piece, status, input ready);
	modport sink (input valid, out_low, out_high, last_piece, status, output ready);
endinterface

`default_nettype wire

>>> rtl/interval_offset_remap_table.sv
// ----------------------------------------------------------------------------
// interval_offset_remap_table
// Table of up to TABLE_ENTRIES ranges with signed offsets, kept sorted by low
// bound; insert, clear, point lookup and range convert into mapped pieces.
// ----------------------------------------------------------------------------
//  channel  role    carries
//  req      sink    command, low_value, high_value, offset
//  rsp      source  out_low, out_high, last_piece, status
//
//  Insert moves the entries above the new low bound up by one slot each (shift walk
//  through the single table write port). Lookup and each convert piece scan every
//  table entry, one entry per cycle. Clear and refused commands go from decode
//  straight to the response transaction.
//  Reset empties the table at once; entry contents are left as they are.
//  A stalled response holds the block; the next request waits for the last piece.
// ----------------------------------------------------------------------------
`default_nettype none

module interval_offset_remap_table #(
	parameter int TABLE_ENTRIES = iort_pkg::DEF_TABLE_ENTRIES,
	parameter int VALUE_BITS    = iort_pkg::DEF_VALUE_BITS
) (
	input  wire       clk,
	input  wire       arst_n,
	iort_in_if.sink   req,
	iort_out_if.source rsp
);

	iort_pkg::ctl_t ctl;
	iort_pkg::sts_t sts;

	// sequencing
	iort_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.rsp_ready (rsp.ready),
		.rsp_valid (rsp.valid),
		.sts       (sts),
		.ctl       (ctl)
	);

	// table and mapping
	iort_dp #(
		.TABLE_ENTRIES (TABLE_ENTRIES),
		.VALUE_BITS    (VALUE_BITS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl         (ctl),
		.sts         (sts),
		.req_command (req.command),
		.req_low     (req.low_value),
		.req_high    (req.high_value),
		.req_offset  (req.offset),
		.out_low     (rsp.out_low),
		.out_high    (rsp.out_high),
		.out_last    (rsp.last_piece),
		.out_status  (rsp.status)
	);

endmodule

`default_nettype wire

>>> rtl/iort_ctrl.sv
// ----------------------------------------------------------------------------
// iort_ctrl
// Controller state machine: sequences decode, the insert shift walk, the
// entry scan per piece and the response handshake.
// ----------------------------------------------------------------------------
`default_nettype none

module iort_ctrl (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                req_valid,
	output logic               req_ready,
	input  wire                rsp_ready,
	output logic               rsp_valid,
	input  wire iort_pkg::sts_t sts,
	output iort_pkg::ctl_t     ctl
);

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_DECODE = 3'd1;
	localparam logic [2:0] S_SHIFT  = 3'd2;
	localparam logic [2:0] S_SCAN   = 3'd3;
	localparam logic [2:0] S_OUT    = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;

	// next state and command decode
	always_comb begin
		state_d   = state_q;
		ctl       = '0;
		ctl.code  = iort_pkg::ST_OK;
		req_ready = 1'b0;
		rsp_valid = 1'b0;
		case (state_q)
			S_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					ctl.accept = 1'b1;
					state_d    = S_DECODE;
				end
			end
			S_DECODE: begin
				case (sts.cmd)
					iort_pkg::CMD_INSERT: begin
						if (sts.lo_gt_hi) begin
							ctl.set_simple = 1'b1;
							ctl.code       = iort_pkg::ST_ORDER;
							state_d        = S_OUT;
						end else if (sts.full) begin
							ctl.set_simple = 1'b1;
							ctl.code       = iort_pkg::ST_FULL;
							state_d        = S_OUT;
						end else begin
							state_d = S_SHIFT;
						end
					end
					iort_pkg::CMD_CLEAR: begin
						ctl.clear_tab  = 1'b1;
						ctl.set_simple = 1'b1;
						state_d        = S_OUT;
					end
					iort_pkg::CMD_LOOKUP: begin
						ctl.scan_init = 1'b1;
						state_d       = S_SCAN;
					end
					default: begin
						if (sts.lo_gt_hi) begin
							ctl.set_simple = 1'b1;
							ctl.code       = iort_pkg::ST_ORDER;
							state_d        = S_OUT;
						end else begin
							ctl.scan_init = 1'b1;
							state_d       = S_SCAN;
						end
					end
				endcase
			end
			S_SHIFT: begin
				if (sts.shift_more) begin
					ctl.shift_step = 1'b1;
				end else begin
					ctl.ins_write = 1'b1;
					state_d       = S_OUT;
				end
			end
			S_SCAN: begin
				if (sts.scan_done) begin
					ctl.load_piece = 1'b1;
					state_d        = S_OUT;
				end else begin
					ctl.scan_step = 1'b1;
				end
			end
			S_OUT: begin
				rsp_valid = 1'b1;
				if (rsp_ready) begin
					if (sts.last_q) begin
						state_d = S_IDLE;
					end else begin
						ctl.next_piece = 1'b1;
						state_d        = S_SCAN;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

`default_nettype wire

>>> rtl/iort_dp.sv
// ----------------------------------------------------------------------------
// iort_dp
// Datapath: the sorted range table, the request registers, the entry scan
// accumulators and the response register with offset mapping.
// ----------------------------------------------------------------------------
`default_nettype none

module iort_dp #(
	parameter int TABLE_ENTRIES = iort_pkg::DEF_TABLE_ENTRIES,
	parameter int VALUE_BITS    = iort_pkg::DEF_VALUE_BITS
) (
	input  wire                                      clk,
	input  wire                                      arst_n,
	input  wire iort_pkg::ctl_t                      ctl,
	output iort_pkg::sts_t                           sts,
	input  wire [iort_pkg::CMD_BITS-1:0]             req_command,
	input  wire [iort_pkg::FIELD_BITS-1:0]           req_low,
	input  wire [iort_pkg::FIELD_BITS-1:0]           req_high,
	input  wire signed [iort_pkg::OFFSET_BITS-1:0]   req_offset,
	output logic [iort_pkg::FIELD_BITS-1:0]          out_low,
	output logic [iort_pkg::FIELD_BITS-1:0]          out_high,
	output logic                                     out_last,
	output logic [iort_pkg::STATUS_BITS-1:0]         out_status
);

	localparam int VW  = VALUE_BITS;
	localparam int OB  = iort_pkg::OFFSET_BITS;
	localparam int CW  = $clog2(TABLE_ENTRIES + 1);
	localparam int AW  = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int MAXP = 2 * TABLE_ENTRIES + 1;
	localparam int PW  = $clog2(MAXP);
	localparam int SW  = ((VW > OB) ? VW : OB) + 2;
	localparam logic [CW-1:0] FULL_CNT  = CW'(TABLE_ENTRIES);
	localparam logic [PW-1:0] LAST_PIECE = PW'(MAXP - 1);

	// range table, contents undefined until written
	logic [VW-1:0]        lows_q [TABLE_ENTRIES];
	logic [VW-1:0]        highs_q [TABLE_ENTRIES];
	logic signed [OB-1:0] offs_q [TABLE_ENTRIES];
	logic [CW-1:0]        count_q;

	// request and walk registers
	logic [iort_pkg::CMD_BITS-1:0] cmd_q;
	logic [VW-1:0]                 cur_q;
	logic [VW-1:0]                 hi_q;
	logic signed [OB-1:0]          off_q;
	logic [CW-1:0]                 idx_q;
	logic                          found_q;
	logic [VW-1:0]                 fhigh_q;
	logic signed [OB-1:0]          foff_q;
	logic                          nvalid_q;
	logic [VW-1:0]                 nlow_q;
	logic [VW-1:0]                 end_q;
	logic [PW-1:0]                 pieces_q;

	// response register
	logic [VW-1:0]                    rlow_q;
	logic [VW-1:0]                    rhigh_q;
	logic                             rlast_q;
	logic [iort_pkg::STATUS_BITS-1:0] rstat_q;

	logic [CW-1:0]        idx_m1;
	logic [AW-1:0]        rd_addr;
	logic [AW-1:0]        sh_addr;
	logic [AW-1:0]        wr_addr;
	logic [VW-1:0]        e_low;
	logic [VW-1:0]        e_high;
	logic                 e_hit;
	logic [VW-1:0]        piece_end;
	logic [VW-1:0]        map_hi_in;
	logic signed [OB-1:0] map_off;
	logic signed [SW-1:0] sum_lo;
	logic signed [SW-1:0] sum_hi;
	logic                 map_bad;
	logic                 piece_last;

	assign idx_m1  = idx_q - CW'(1);
	assign rd_addr = idx_q[AW-1:0];
	assign sh_addr = idx_m1[AW-1:0];
	assign wr_addr = idx_q[AW-1:0];

	// entry under the scan pointer
	assign e_low  = lows_q[rd_addr];
	assign e_high = highs_q[rd_addr];
	assign e_hit  = (e_low <= cur_q) && (cur_q <= e_high);

	// status toward the controller
	always_comb begin
		sts.cmd        = cmd_q;
		sts.lo_gt_hi   = cur_q > hi_q;
		sts.full       = count_q >= FULL_CNT;
		sts.shift_more = (idx_q != '0) && (lows_q[sh_addr] > cur_q);
		sts.scan_done  = idx_q >= count_q;
		sts.last_q     = rlast_q;
	end

	// piece end: lookup point, or query end cut by covering entry or next start
	always_comb begin
		if (cmd_q == iort_pkg::CMD_LOOKUP) begin
			piece_end = cur_q;
		end else if (found_q) begin
			piece_end = (fhigh_q < hi_q) ? fhigh_q : hi_q;
		end else if (nvalid_q && ((nlow_q - VW'(1)) < hi_q)) begin
			piece_end = nlow_q - VW'(1);
		end else begin
			piece_end = hi_q;
		end
		map_hi_in  = piece_end;
		map_off    = found_q ? foff_q : '0;
		piece_last = (cmd_q == iort_pkg::CMD_LOOKUP) || (piece_end == hi_q) ||
			(pieces_q == LAST_PIECE);
	end

	// offset mapping with range check
	assign sum_lo  = $signed({{(SW - VW){1'b0}}, cur_q}) + SW'(map_off);
	assign sum_hi  = $signed({{(SW - VW){1'b0}}, map_hi_in}) + SW'(map_off);
	assign map_bad = (sum_lo[SW-1:VW] != '0) || (sum_hi[SW-1:VW] != '0);

	// table storage writes
	always_ff @(posedge clk) begin
		if (ctl.shift_step) begin
			lows_q[wr_addr]  <= lows_q[sh_addr];
			highs_q[wr_addr] <= highs_q[sh_addr];
			offs_q[wr_addr]  <= offs_q[sh_addr];
		end else if (ctl.ins_write) begin
			lows_q[wr_addr]  <= cur_q;
			highs_q[wr_addr] <= hi_q;
			offs_q[wr_addr]  <= off_q;
		end
	end

	// entry count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (ctl.clear_tab) begin
			count_q <= '0;
		end else if (ctl.ins_write) begin
			count_q <= count_q + CW'(1);
		end
	end

	// request fields, walk pointer and scan accumulators
	always_ff @(posedge clk) begin
		if (ctl.accept) begin
			cmd_q    <= req_command;
			cur_q    <= VW'(req_low);
			hi_q     <= VW'(req_high);
			off_q    <= req_offset;
			idx_q    <= count_q;
			pieces_q <= '0;
		end
		if (ctl.shift_step) begin
			idx_q <= idx_m1;
		end
		if (ctl.scan_init || ctl.next_piece) begin
			idx_q    <= '0;
			found_q  <= 1'b0;
			nvalid_q <= 1'b0;
		end
		if (ctl.next_piece) begin
			cur_q    <= end_q + VW'(1);
			pieces_q <= pieces_q + PW'(1);
		end
		if (ctl.scan_step) begin
			idx_q <= idx_q + CW'(1);
			if (!found_q && e_hit) begin
				found_q <= 1'b1;
				fhigh_q <= e_high;
				foff_q  <= offs_q[rd_addr];
			end
			if ((e_low > cur_q) && (!nvalid_q || (e_low < nlow_q))) begin
				nvalid_q <= 1'b1;
				nlow_q   <= e_low;
			end
		end
		if (ctl.load_piece) begin
			end_q <= piece_end;
		end
	end

	// response register
	always_ff @(posedge clk) begin
		if (ctl.set_simple) begin
			rlow_q  <= '0;
			rhigh_q <= '0;
			rlast_q <= 1'b1;
			rstat_q <= ctl.code;
		end else if (ctl.ins_write) begin
			rlow_q  <= '0;
			rhigh_q <= '0;
			rlast_q <= 1'b1;
			rstat_q <= iort_pkg::ST_OK;
		end else if (ctl.load_piece) begin
			rlast_q <= piece_last;
			if (map_bad) begin
				rlow_q  <= '0;
				rhigh_q <= '0;
				rstat_q <= iort_pkg::ST_RANGE;
			end else begin
				rlow_q  <= sum_lo[VW-1:0];
				rhigh_q <= sum_hi[VW-1:0];
				rstat_q <= iort_pkg::ST_OK;
			end
		end
	end

	assign out_low    = iort_pkg::FIELD_BITS'(rlow_q);
	assign out_high   = iort_pkg::FIELD_BITS'(rhigh_q);
	assign out_last   = rlast_q;
	assign out_status = rstat_q;

endmodule

`default_nettype wire

>>> tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives insert, clear, lookup and convert requests into the remap table and
// checks every response piece against a behavioral table kept in a scoreboard,
// under random valid and ready gaps on both channels.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import iort_pkg::*;

	localparam int ENTRIES = DEF_TABLE_ENTRIES;
	localparam logic [FIELD_BITS-1:0] VMAX = '1;
	localparam longint VMAX_L = (64'd1 << DEF_VALUE_BITS) - 1;
	localparam int IDLE_LIMIT = 20000;

	typedef struct {
		logic [FIELD_BITS-1:0]  lo;
		logic [FIELD_BITS-1:0]  hi;
		logic                   last;
		logic [STATUS_BITS-1:0] status;
	} piece_t;

	// behavioral table and queue of expected pieces
	class remap_scoreboard;
		logic [FIELD_BITS-1:0]         lows[ENTRIES];
		logic [FIELD_BITS-1:0]         highs[ENTRIES];
		logic signed [OFFSET_BITS-1:0] offs[ENTRIES];
		int unsigned                   count;
		piece_t                        pieces_q[$];
		int                            mismatches;

		function new();
			count = 0;
			mismatches = 0;
		endfunction

		function void push_piece(logic [FIELD_BITS-1:0] lo, logic [FIELD_BITS-1:0] hi,
				logic last, logic [STATUS_BITS-1:0] status);
			piece_t p;
			p.lo = lo;
			p.hi = hi;
			p.last = last;
			p.status = status;
			pieces_q.insert(pieces_q.size(), p);
		endfunction

		// shift a piece, out of range gives a zero piece
		function void push_mapped(logic [FIELD_BITS-1:0] lo, logic [FIELD_BITS-1:0] hi,
				logic signed [OFFSET_BITS-1:0] off, logic last);
			longint a;
			longint b;
			a = longint'(lo) + longint'(off);
			b = longint'(hi) + longint'(off);
			if (a < 0 || b < 0 || a > VMAX_L || b > VMAX_L)
				push_piece('0, '0, last, ST_RANGE);
			else
				push_piece(a[FIELD_BITS-1:0], b[FIELD_BITS-1:0], last, ST_OK);
		endfunction

		function int find_entry(logic [FIELD_BITS-1:0] p);
			for (int i = 0; i < count; i++)
				if (lows[i] <= p && p <= highs[i])
					return i;
			return -1;
		endfunction

		function void note_request(logic [CMD_BITS-1:0] cmd, logic [FIELD_BITS-1:0] lo,
				logic [FIELD_BITS-1:0] hi, logic signed [OFFSET_BITS-1:0] off);
			int pos;
			int e;
			int n;
			logic [FIELD_BITS-1:0] cur;
			logic [FIELD_BITS-1:0] stop;
			logic signed [OFFSET_BITS-1:0] sh;
			logic last;
			case (cmd)
				CMD_INSERT: begin
					if (lo > hi)
						push_piece('0, '0, 1'b1, ST_ORDER);
					else if (count >= ENTRIES)
						push_piece('0, '0, 1'b1, ST_FULL);
					else begin
						pos = 0;
						while (pos < count && lows[pos] <= lo)
							pos++;
						for (int i = count; i > pos; i--) begin
							lows[i] = lows[i-1];
							highs[i] = highs[i-1];
							offs[i] = offs[i-1];
						end
						lows[pos] = lo;
						highs[pos] = hi;
						offs[pos] = off;
						count++;
						push_piece('0, '0, 1'b1, ST_OK);
					end
				end
				CMD_CLEAR: begin
					count = 0;
					push_piece('0, '0, 1'b1, ST_OK);
				end
				CMD_LOOKUP: begin
					e = find_entry(lo);
					push_mapped(lo, lo, (e >= 0) ? offs[e] : '0, 1'b1);
				end
				default: begin
					// convert: walk the query range piece by piece
					if (lo > hi)
						push_piece('0, '0, 1'b1, ST_ORDER);
					else begin
						n = 0;
						cur = lo;
						do begin
							e = find_entry(cur);
							sh = '0;
							if (e >= 0) begin
								stop = (highs[e] < hi) ? highs[e] : hi;
								sh = offs[e];
							end else begin
								stop = hi;
								for (int i = 0; i < count; i++)
									if (lows[i] > cur && lows[i] - 1 < stop)
										stop = lows[i] - 1;
							end
							last = (stop == hi) || (n == 2 * ENTRIES);
							push_mapped(cur, stop, sh, last);
							n++;
							cur = stop + 1;
						end while (!last);
					end
				end
			endcase
		endfunction

		function void check_result(logic [FIELD_BITS-1:0] lo, logic [FIELD_BITS-1:0] hi,
				logic last, logic [STATUS_BITS-1:0] status);
			piece_t p;
			if (pieces_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected piece lo=%h hi=%h last=%b status=%0d",
						lo, hi, last, status);
				return;
			end
			p = pieces_q.pop_front();
			if (p.lo !== lo || p.hi !== hi || p.last !== last || p.status !== status) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch exp lo=%h hi=%h last=%b status=%0d, got lo=%h hi=%h last=%b status=%0d",
						p.lo, p.hi, p.last, p.status, lo, hi, last, status);
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;

	iort_in_if  req ();
	iort_out_if rsp ();

	interval_offset_remap_table i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req.sink),
		.rsp    (rsp.source)
	);

	remap_scoreboard sb = new();
	int send_idle;
	int recv_idle;
	int idle_cycles;
	logic [FIELD_BITS-1:0] window_base;

	// clock
	initial clk = 1'b0;
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// response side: check accepted pieces, randomize ready
	always @(posedge clk) begin
		if (rsp.valid && rsp.ready)
			sb.check_result(rsp.out_low, rsp.out_high, rsp.last_piece, rsp.status);
		rsp.ready <= ($urandom_range(99) >= recv_idle);
	end

	// watchdog on cycles without any transaction
	always @(posedge clk) begin
		if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > IDLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// one request transaction with random gaps ahead of it
	task automatic send_request(logic [CMD_BITS-1:0] cmd, logic [FIELD_BITS-1:0] lo,
			logic [FIELD_BITS-1:0] hi, logic signed [OFFSET_BITS-1:0] off);
		while ($urandom_range(99) < send_idle) begin
			req.valid <= 1'b0;
			@(posedge clk);
		end
		req.valid      <= 1'b1;
		req.command    <= cmd;
		req.low_value  <= lo;
		req.high_value <= hi;
		req.offset     <= off;
		do
			@(posedge clk);
		while (!req.ready);
		sb.note_request(cmd, lo, hi, off);
	endtask

	task automatic wait_drained();
		req.valid <= 1'b0;
		while (sb.pieces_q.size() != 0)
			@(posedge clk);
	endtask

	function automatic logic [FIELD_BITS-1:0] rand_value();
		logic [63:0] r;
		r = {$urandom, $urandom};
		return r[FIELD_BITS-1:0];
	endfunction

	// value near the current window, or anywhere
	function automatic logic [FIELD_BITS-1:0] pick_value();
		if ($urandom_range(99) < 75)
			return window_base + FIELD_BITS'($urandom_range(0, 300));
		return rand_value();
	endfunction

	function automatic logic signed [OFFSET_BITS-1:0] pick_offset();
		logic [63:0] r;
		int k;
		k = $urandom_range(99);
		if (k < 50)
			return OFFSET_BITS'($signed($urandom_range(0, 600)) - 300);
		if (k < 65)
			return $urandom_range(1) ? OFFSET_BITS'(VMAX) : -OFFSET_BITS'(VMAX);
		r = {$urandom, $urandom};
		// most negative code lies outside the field range
		if (r[OFFSET_BITS-1:0] == {1'b1, {FIELD_BITS{1'b0}}})
			return '0;
		return r[OFFSET_BITS-1:0];
	endfunction

	task automatic random_request();
		logic [FIELD_BITS-1:0] a;
		logic [FIELD_BITS-1:0] b;
		logic [FIELD_BITS-1:0] t;
		int k;
		k = $urandom_range(99);
		a = pick_value();
		b = ($urandom_range(99) < 60) ? a + FIELD_BITS'($urandom_range(0, 60)) : pick_value();
		if (a > b && $urandom_range(99) < 85) begin
			t = a;
			a = b;
			b = t;
		end
		if (k < 4 || (sb.count >= ENTRIES && k < 30)) begin
			send_request(CMD_CLEAR, rand_value(), rand_value(), pick_offset());
			case ($urandom_range(2))
				0: window_base = '0;
				1: window_base = VMAX - 300;
				default: window_base = rand_value();
			endcase
		end else if (k < 45)
			send_request(CMD_INSERT, a, b, pick_offset());
		else if (k < 80)
			send_request(CMD_CONVERT, a, b, pick_offset());
		else
			send_request(CMD_LOOKUP, a, b, pick_offset());
	endtask

	initial begin
		arst_n         = 1'b0;
		req.valid      = 1'b0;
		req.command    = CMD_INSERT;
		req.low_value  = '0;
		req.high_value = '0;
		req.offset     = '0;
		rsp.ready      = 1'b0;
		idle_cycles    = 0;
		window_base    = '0;
		send_idle      = 14;
		recv_idle      = 78;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: ordering errors, overlaps, equal lows, extremes, full table
		send_request(CMD_LOOKUP, VMAX, '0, '0);
		send_request(CMD_CONVERT, '0, VMAX, '0);
		send_request(CMD_INSERT, 40'd5, 40'd4, '0);
		send_request(CMD_INSERT, '0, '0, OFFSET_BITS'(VMAX));
		send_request(CMD_INSERT, 40'd100, 40'd200, -41'sd50);
		send_request(CMD_INSERT, 40'd150, 40'd300, 41'sd1000);
		send_request(CMD_INSERT, 40'd100, 40'd120, 41'sd7);
		send_request(CMD_INSERT, VMAX - 10, VMAX, 41'sd1);
		send_request(CMD_INSERT, 40'd20, 40'd30, -OFFSET_BITS'(VMAX));
		send_request(CMD_LOOKUP, '0, '0, '0);
		send_request(CMD_LOOKUP, 40'd110, '0, '0);
		send_request(CMD_LOOKUP, 40'd250, '0, '0);
		send_request(CMD_LOOKUP, 40'd50, '0, '0);
		send_request(CMD_LOOKUP, VMAX, '0, '0);
		send_request(CMD_CONVERT, '0, VMAX, '0);
		send_request(CMD_CONVERT, 40'd300, 40'd100, '0);
		send_request(CMD_CONVERT, 40'd120, 40'd160, '0);
		for (int i = 0; i < 11; i++)
			send_request(CMD_INSERT, 40'd1000 + 40'(i * 20), 40'd1009 + 40'(i * 20),
				41'(i * 3));
		send_request(CMD_CONVERT, '0, 40'd1300, '0);
		send_request(CMD_CLEAR, '0, '0, '0);

		// hold off until everything directed has drained
		wait_drained();

		// random: three idle profiles
		repeat (120) random_request();
		send_idle = 78;
		recv_idle = 14;
		repeat (120) random_request();
		send_idle = 0;
		recv_idle = 0;
		repeat (130) random_request();

		wait_drained();
		repeat (100) @(posedge clk);
		if (sb.mismatches == 0 && sb.pieces_q.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

`default_nettype wire
